// ===== rtl/deq_pkg.sv =====
// types, constants and codes shared by the double-ended queue unit
package deq_pkg;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_BITS  = $clog2(DEPTH);
  localparam int unsigned CNT_BITS  = $clog2(DEPTH + 1);
  localparam int unsigned OP_BITS   = 3;
  localparam int unsigned ST_BITS   = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } deq_op_e;

  typedef enum logic [ST_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } deq_status_e;

  // what every cell of a chain does with its word
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_LEFT  = 2'd1,
    CELL_TAKE_RIGHT = 2'd2,
    CELL_APPEND     = 2'd3
  } deq_cell_op_e;

  typedef struct packed {
    deq_cell_op_e          cmd;
    logic [CNT_BITS-1:0]   count;
    logic [WORD_BITS-1:0]  word;
  } deq_ctrl_t;

  typedef struct packed {
    logic [OP_BITS-1:0]          operation;
    logic signed [WORD_BITS-1:0] item_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] popped_value;
    logic [ST_BITS-1:0]          status;
    logic [CNT_BITS-1:0]         entry_total;
    logic                        empty_flag;
    logic signed [WORD_BITS-1:0] front_value;
    logic signed [WORD_BITS-1:0] back_value;
  } deq_out_t;

endpackage

// ===== rtl/double_ended_queue_unit.sv =====
// bounded double-ended queue built from two mirrored shifting cell chains
// latency: a result is valid in the cycle after its input transfer
// throughput: one item per cycle while each result is taken; the output register frees when its result transfers
// every operation moves all cells of both chains by at most one place
// reset clears the entry count and the output valid; cell contents are not reset
module double_ended_queue_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  deq_pkg::deq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_out_t out_data_o
);

  // entry count, shared by both chains
  logic [deq_pkg::CNT_BITS-1:0] cnt_q, cnt_d;

  // output register
  logic              out_valid_q, out_valid_d;
  deq_pkg::deq_out_t out_q, out_d;

  logic in_fire;
  logic is_push_front, is_push_back, is_pop_front, is_pop_back;
  logic full, empty;
  logic do_push_front, do_push_back, do_pop_front, do_pop_back;

  // front chain: cell zero holds the front, elements in queue order
  // back chain: cell zero holds the back, elements in reverse order
  deq_pkg::deq_ctrl_t fwd_ctrl, rev_ctrl;
  logic [deq_pkg::WORD_BITS-1:0] fwd_head, fwd_next, rev_head, rev_next;

  logic [deq_pkg::WORD_BITS-1:0] front_after, back_after, popped;
  logic [deq_pkg::ST_BITS-1:0]   status;

  assign in_fire = in_valid_i && in_ready_o;

  // take a new item whenever the output register is empty or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;

  assign is_push_front = (in_data_i.operation == deq_pkg::OP_PUSH_FRONT);
  assign is_push_back  = (in_data_i.operation == deq_pkg::OP_PUSH_BACK);
  assign is_pop_front  = (in_data_i.operation == deq_pkg::OP_POP_FRONT);
  assign is_pop_back   = (in_data_i.operation == deq_pkg::OP_POP_BACK);

  assign full  = (cnt_q == deq_pkg::CNT_BITS'(deq_pkg::DEPTH));
  assign empty = (cnt_q == '0);

  assign do_push_front = in_fire && is_push_front && !full;
  assign do_push_back  = in_fire && is_push_back  && !full;
  assign do_pop_front  = in_fire && is_pop_front  && !empty;
  assign do_pop_back   = in_fire && is_pop_back   && !empty;

  // chain commands: a push at one end shifts that end's chain and appends
  // the word past the live entries of the other chain; a pop shifts its
  // own chain back and leaves stale words in the other chain
  always_comb begin
    fwd_ctrl.count = cnt_q;
    fwd_ctrl.word  = in_data_i.item_value;
    rev_ctrl.count = cnt_q;
    rev_ctrl.word  = in_data_i.item_value;
    fwd_ctrl.cmd   = deq_pkg::CELL_HOLD;
    rev_ctrl.cmd   = deq_pkg::CELL_HOLD;
    if (do_push_front) begin
      fwd_ctrl.cmd = deq_pkg::CELL_TAKE_LEFT;
      rev_ctrl.cmd = deq_pkg::CELL_APPEND;
    end else if (do_push_back) begin
      fwd_ctrl.cmd = deq_pkg::CELL_APPEND;
      rev_ctrl.cmd = deq_pkg::CELL_TAKE_LEFT;
    end else if (do_pop_front) begin
      fwd_ctrl.cmd = deq_pkg::CELL_TAKE_RIGHT;
    end else if (do_pop_back) begin
      rev_ctrl.cmd = deq_pkg::CELL_TAKE_RIGHT;
    end
  end

  deq_chain u_fwd_chain (
    .clk_i  (clk_i),
    .ctrl_i (fwd_ctrl),
    .head_o (fwd_head),
    .next_o (fwd_next)
  );

  deq_chain u_rev_chain (
    .clk_i  (clk_i),
    .ctrl_i (rev_ctrl),
    .head_o (rev_head),
    .next_o (rev_next)
  );

  // count after the operation
  always_comb begin
    cnt_d = cnt_q;
    if (do_push_front || do_push_back) begin
      cnt_d = cnt_q + deq_pkg::CNT_BITS'(1);
    end else if (do_pop_front || do_pop_back) begin
      cnt_d = cnt_q - deq_pkg::CNT_BITS'(1);
    end
  end

  // front and back words as the chains will hold them after this operation, with the popped word and status
  always_comb begin
    front_after = fwd_head;
    back_after  = rev_head;
    popped      = '1;
    status      = deq_pkg::ST_OK;
    if (is_push_front || is_push_back) begin
      if (full) begin
        status = deq_pkg::ST_PUSH_FULL;
      end else if (is_push_front) begin
        front_after = in_data_i.item_value;
        if (empty) begin
          back_after = in_data_i.item_value;
        end
      end else begin
        back_after = in_data_i.item_value;
        if (empty) begin
          front_after = in_data_i.item_value;
        end
      end
    end else if (is_pop_front || is_pop_back) begin
      if (empty) begin
        status = deq_pkg::ST_POP_EMPTY;
      end else if (is_pop_front) begin
        popped      = fwd_head;
        front_after = fwd_next;
      end else begin
        popped     = rev_head;
        back_after = rev_next;
      end
    end
  end

  // result for the output register
  always_comb begin
    out_d              = out_q;
    out_valid_d        = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d              = 1'b1;
      out_d.popped_value       = popped;
      out_d.status             = status;
      out_d.entry_total        = cnt_d;
      out_d.empty_flag         = (cnt_d == '0);
      out_d.front_value        = (cnt_d == '0) ? '1 : front_after;
      out_d.back_value         = (cnt_d == '0) ? '1 : back_after;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // count never passes the capacity
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= deq_pkg::CNT_BITS'(deq_pkg::DEPTH))
    else $error("entry count above capacity");

  // with a single entry the result shows the same word at front and back
  a_single_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.entry_total == deq_pkg::CNT_BITS'(1)
      |-> out_q.front_value == out_q.back_value)
    else $error("front and back differ with one entry");

  // pop on an empty queue reports the error in the next result
  a_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (is_pop_front || is_pop_back) && empty
      |=> out_valid_q && out_q.status == deq_pkg::ST_POP_EMPTY && cnt_q == '0)
    else $error("pop on empty queue misreported");

  // a dropped push leaves the count alone
  a_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (is_push_front || is_push_back) && full
      |=> cnt_q == $past(cnt_q) && out_q.status == deq_pkg::ST_PUSH_FULL)
    else $error("push on full queue changed state");

  // empty results show the empty marker at both ends
  a_empty_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.empty_flag
      |-> out_q.entry_total == '0 && out_q.front_value == '1 && out_q.back_value == '1)
    else $error("empty result with live end words");

endmodule

// ===== rtl/deq_cell.sv =====
// one storage cell of a shifting word chain
module deq_cell (
  input  logic                               clk_i,
  input  deq_pkg::deq_ctrl_t                 ctrl_i,
  input  logic [deq_pkg::IDX_BITS-1:0]       idx_i,
  input  logic [deq_pkg::WORD_BITS-1:0]      left_i,
  input  logic [deq_pkg::WORD_BITS-1:0]      right_i,
  output logic [deq_pkg::WORD_BITS-1:0]      word_o
);

  logic [deq_pkg::WORD_BITS-1:0] word_q, word_d;
  logic                          at_end;

  // this cell is the first free slot of the chain
  assign at_end = (ctrl_i.count == deq_pkg::CNT_BITS'(idx_i));

  always_comb begin
    word_d = word_q;
    unique case (ctrl_i.cmd)
      deq_pkg::CELL_HOLD:       word_d = word_q;
      deq_pkg::CELL_TAKE_LEFT:  word_d = left_i;
      deq_pkg::CELL_TAKE_RIGHT: word_d = right_i;
      deq_pkg::CELL_APPEND:     word_d = at_end ? ctrl_i.word : word_q;
      default:                  word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== rtl/deq_chain.sv =====
// row of cells holding the queue in order, element zero at cell zero
module deq_chain (
  input  logic                          clk_i,
  input  deq_pkg::deq_ctrl_t            ctrl_i,
  output logic [deq_pkg::WORD_BITS-1:0] head_o,
  output logic [deq_pkg::WORD_BITS-1:0] next_o
);

  logic [deq_pkg::WORD_BITS-1:0] cell_word [deq_pkg::DEPTH];
  logic [deq_pkg::WORD_BITS-1:0] left_word [deq_pkg::DEPTH];
  logic [deq_pkg::WORD_BITS-1:0] right_word[deq_pkg::DEPTH];

  for (genvar i = 0; i < int'(deq_pkg::DEPTH); i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_word[i] = ctrl_i.word;
    end else begin : g_mid_l
      assign left_word[i] = cell_word[i-1];
    end
    if (i == int'(deq_pkg::DEPTH) - 1) begin : g_last
      assign right_word[i] = cell_word[i];
    end else begin : g_mid_r
      assign right_word[i] = cell_word[i+1];
    end

    deq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (deq_pkg::IDX_BITS'(i)),
      .left_i  (left_word[i]),
      .right_i (right_word[i]),
      .word_o  (cell_word[i])
    );
  end

  assign head_o = cell_word[0];
  assign next_o = cell_word[1];

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the double-ended queue unit
module tb_top;
  import deq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [OP_BITS-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_BITS-1:0] OP_UNUSED_LAST = 3'd7;

  // reference deque kept in step with accepted requests, plus the queue of responses it owes
  class deque_scoreboard;
    logic [WORD_BITS-1:0] words [DEPTH];
    logic [IDX_BITS-1:0] front_idx;
    logic [CNT_BITS-1:0] live_count;
    deq_out_t pending_responses [$];
    int requests_seen;
    int responses_checked;
    int mismatches;
    int full_drops;
    int empty_pops;
    int peak_level;

    function new();
      front_idx = '0;
      live_count = '0;
      requests_seen = 0;
      responses_checked = 0;
      mismatches = 0;
      full_drops = 0;
      empty_pops = 0;
      peak_level = 0;
    endfunction

    function int level();
      return int'(live_count);
    endfunction

    function int pending();
      return pending_responses.size();
    endfunction

    // apply one request to the reference deque and build its response
    function deq_out_t predict_response(deq_in_t req);
      deq_out_t rsp;
      logic [IDX_BITS-1:0] slot;
      rsp = '0;
      rsp.popped_value = '1;
      rsp.status = ST_OK;
      case (req.operation)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (live_count == CNT_BITS'(DEPTH)) begin
            rsp.status = ST_PUSH_FULL;
            full_drops++;
          end else if (req.operation == OP_PUSH_FRONT) begin
            front_idx = front_idx - 1'b1;
            words[front_idx] = req.item_value;
            live_count++;
          end else begin
            slot = front_idx + live_count[IDX_BITS-1:0];
            words[slot] = req.item_value;
            live_count++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (live_count == '0) begin
            rsp.status = ST_POP_EMPTY;
            empty_pops++;
          end else if (req.operation == OP_POP_FRONT) begin
            rsp.popped_value = words[front_idx];
            front_idx = front_idx + 1'b1;
            live_count--;
          end else begin
            slot = front_idx + live_count[IDX_BITS-1:0] - 1'b1;
            rsp.popped_value = words[slot];
            live_count--;
          end
        end
        default: ;
      endcase
      rsp.entry_total = live_count;
      rsp.empty_flag = (live_count == '0);
      if (live_count == '0) begin
        rsp.front_value = '1;
        rsp.back_value = '1;
      end else begin
        slot = front_idx + live_count[IDX_BITS-1:0] - 1'b1;
        rsp.front_value = words[front_idx];
        rsp.back_value = words[slot];
      end
      if (int'(live_count) > peak_level) peak_level = int'(live_count);
      return rsp;
    endfunction

    function void note_request(deq_in_t req);
      requests_seen++;
      pending_responses = {pending_responses, predict_response(req)};
    endfunction

    function bit field_differs(string name, logic [WORD_BITS-1:0] exp_v,
                               logic [WORD_BITS-1:0] act_v);
      if (act_v === exp_v) return 1'b0;
      $display("%0t: mismatch on %s, expected %h, got %h", $time, name, exp_v, act_v);
      return 1'b1;
    endfunction

    function void check_response(deq_out_t got);
      deq_out_t want;
      bit bad;
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_responses[0];
      pending_responses.delete(0);
      bad = 1'b0;
      bad |= field_differs("popped_value", want.popped_value, got.popped_value);
      bad |= field_differs("status", WORD_BITS'(want.status), WORD_BITS'(got.status));
      bad |= field_differs("entry_total", WORD_BITS'(want.entry_total),
                           WORD_BITS'(got.entry_total));
      bad |= field_differs("empty_flag", WORD_BITS'(want.empty_flag),
                           WORD_BITS'(got.empty_flag));
      bad |= field_differs("front_value", want.front_value, got.front_value);
      bad |= field_differs("back_value", want.back_value, got.back_value);
      if (bad) mismatches++;
      responses_checked++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  deq_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  deq_out_t out_data_o;

  deque_scoreboard sb;
  int unsigned cycle_count;
  bit burst_mode;

  double_ended_queue_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               sb.pending());
      $display("** double_ended_queue_unit: FAILED **");
      $finish;
    end
  end

  // both transfers are observed at the rising edge; the response is checked first since
  // it always belongs to an earlier request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_response(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
    end
  end

  // receiver: ready runs, short and long stalls, and one long hold-off that backs up the input
  initial begin
    bit hold_done;
    int r;
    int len;
    bit rdy;
    hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (!hold_done && sb.requests_seen >= 40) begin
        rdy = 1'b0;
        len = 150;
        hold_done = 1'b1;
      end else if (r < 45) begin
        rdy = 1'b1;
        len = $urandom_range(1, 20);
      end else if (r < 50) begin
        rdy = 1'b1;
        len = 100;
      end else if (r < 95) begin
        rdy = 1'b0;
        len = $urandom_range(1, 3);
      end else begin
        rdy = 1'b0;
        len = $urandom_range(20, 60);
      end
      out_ready_i <= rdy;
      repeat (len) @(negedge clk_i);
    end
  end

  function automatic int next_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: return {1'b1, {(WORD_BITS-1){1'b0}}};
      1: return {1'b0, {(WORD_BITS-1){1'b1}}};
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic deq_in_t make_req(logic [OP_BITS-1:0] op, logic [WORD_BITS-1:0] val);
    deq_in_t req;
    req.operation = op;
    req.item_value = val;
    return req;
  endfunction

  // valid goes up at a falling edge and holds until the transfer, then drops for the gap
  task automatic send_req(deq_in_t req);
    int gap;
    gap = next_gap();
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (!in_ready_o);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic logic [OP_BITS-1:0] pick_op(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return OP_BITS'($urandom_range(int'(OP_PUSH_FRONT), int'(OP_PUSH_BACK)));
    if (r < push_pct + pop_pct)
      return OP_BITS'($urandom_range(int'(OP_POP_FRONT), int'(OP_POP_BACK)));
    if ($urandom_range(0, 3) == 0) return OP_NONE;
    return OP_BITS'($urandom_range(int'(OP_UNUSED_FIRST), int'(OP_UNUSED_LAST)));
  endfunction

  // random traffic with a given mix; stops early when the deque reaches stop_level
  task automatic run_traffic(int count, int stop_level, int push_pct, int pop_pct);
    for (int i = 0; i < count && sb.level() != stop_level; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_req(make_req(pick_op(push_pct, pop_pct), rand_word()));
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    burst_mode = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pops, idle and unused codes, extreme words, head wrap below zero,
    // popping the last entry, and mixed ends
    send_req(make_req(OP_POP_FRONT, '0));
    send_req(make_req(OP_POP_BACK, '1));
    send_req(make_req(OP_NONE, 32'h1234_5678));
    send_req(make_req(OP_UNUSED_FIRST, 32'h8000_0000));
    send_req(make_req(OP_UNUSED_FIRST + 3'd1, 32'h7fff_ffff));
    send_req(make_req(OP_UNUSED_LAST, 32'hffff_ffff));
    send_req(make_req(OP_PUSH_FRONT, 32'h8000_0000));
    send_req(make_req(OP_PUSH_BACK, 32'h7fff_ffff));
    send_req(make_req(OP_PUSH_FRONT, 32'hffff_ffff));
    send_req(make_req(OP_PUSH_BACK, 32'h0000_0000));
    send_req(make_req(OP_PUSH_FRONT, 32'h0000_0001));
    send_req(make_req(OP_NONE, 32'hdead_beef));
    send_req(make_req(OP_POP_BACK, '0));
    send_req(make_req(OP_POP_FRONT, '0));
    send_req(make_req(OP_POP_FRONT, '0));
    send_req(make_req(OP_POP_BACK, '0));
    send_req(make_req(OP_POP_BACK, '0));
    send_req(make_req(OP_POP_FRONT, '0));
    send_req(make_req(OP_PUSH_BACK, 32'h5555_5555));
    send_req(make_req(OP_PUSH_FRONT, 32'haaaa_aaaa));
    send_req(make_req(OP_UNUSED_LAST, 32'h0f0f_0f0f));
    send_req(make_req(OP_POP_FRONT, '0));
    send_req(make_req(OP_POP_BACK, '0));

    // balanced churn around a shallow deque
    run_traffic(150, -1, 40, 40);
    // push-heavy run that builds a deeper deque
    run_traffic(200, -1, 85, 10);
    // drain to empty, then pops that must report an empty deque
    run_traffic(260, 0, 5, 90);
    for (int i = 0; i < 6; i++) send_req(make_req(pick_op(0, 100), rand_word()));
    run_traffic(100, -1, 45, 40);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("run: %0d requests, %0d responses checked, peak depth %0d of %0d",
             sb.requests_seen, sb.responses_checked, sb.peak_level, DEPTH);
    $display("     %0d pushes dropped on full, %0d pops on empty, %0d mismatching responses",
             sb.full_drops, sb.empty_pops, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** double_ended_queue_unit: PASSED **");
    end else begin
      $display("** double_ended_queue_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/deq_chain.sv
rtl/double_ended_queue_unit.sv
test/tb_top.sv
